/* rtl/rdc_pkg.sv */
// Shared types and constants for the radix digit converter.
package rdc_pkg;

    localparam int RADIX_W       = 4;
    localparam int DIGIT_W       = 4;
    localparam int DIV_STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd10;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic pop;
    } rdc_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic last_digit;
    } rdc_sts_t;

endpackage

/* rtl/rdc_dp.sv */
// Datapath: chunked restoring divider by the radix and a digit stack.
module rdc_dp #(
    parameter int VALUE_WIDTH = 31,
    parameter int NCHUNK      = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdc_pkg::rdc_cmd_t             cmd,
    output rdc_pkg::rdc_sts_t             sts,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic [rdc_pkg::RADIX_W-1:0]   radix,
    output logic [rdc_pkg::DIGIT_W-1:0]   digit,
    output logic                          last
);
    import rdc_pkg::*;

    localparam int PW = NCHUNK * DIV_STEP_BITS;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [PW-1:0]          dvd_reg, dvd_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     radix_clamped;
    logic [DIGIT_W-1:0]     stack_reg [VALUE_WIDTH];
    logic [CNT_W-1:0]       cnt_reg;

    always_comb
    begin
        if (radix < RADIX_MIN)
            radix_clamped = RADIX_MIN;
        else if (radix > RADIX_MAX)
            radix_clamped = RADIX_MAX;
        else
            radix_clamped = radix;
    end

    // Eight restoring division steps per cycle, MSB first.
    always_comb
    begin
        logic [RADIX_W:0]         trial;
        logic [RADIX_W-1:0]       r;
        logic [DIV_STEP_BITS-1:0] chunk;
        logic [DIV_STEP_BITS-1:0] qbits;
        r     = rem_reg;
        chunk = dvd_reg[PW-1 -: DIV_STEP_BITS];
        qbits = '0;
        for (int i = DIV_STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {r, chunk[i]};
            if (trial >= {1'b0, radix_reg})
            begin
                trial    = trial - {1'b0, radix_reg};
                qbits[i] = 1'b1;
            end
            r = trial[RADIX_W-1:0];
        end
        rem_next = r;
        dvd_next = (dvd_reg << DIV_STEP_BITS) | PW'(qbits);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.push)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg   <= PW'(value);
            rem_reg   <= '0;
            radix_reg <= radix_clamped;
        end
        else if (cmd.step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        else if (cmd.push)
        begin
            rem_reg <= '0;
        end
    end

    // LIFO: top of stack at entry 0.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_reg[0] <= rem_reg;
            for (int i = 1; i < VALUE_WIDTH; i++)
                stack_reg[i] <= stack_reg[i-1];
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < VALUE_WIDTH - 1; i++)
                stack_reg[i] <= stack_reg[i+1];
        end
    end

    assign sts.quot_zero  = (dvd_reg == '0);
    assign sts.last_digit = (cnt_reg == CNT_W'(1));
    assign digit          = stack_reg[0];
    assign last           = sts.last_digit;

endmodule

/* rtl/rdc_ctrl.sv */
// Controller: sequences load, divide, push and emit phases.
module rdc_ctrl #(
    parameter int NCHUNK = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              strobe,
    output rdc_pkg::rdc_cmd_t cmd,
    input  rdc_pkg::rdc_sts_t sts
);
    import rdc_pkg::*;

    localparam int CW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   chunk_reg;

    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == ST_IDLE) && start;
        cmd.step = (state_reg == ST_DIV);
        cmd.push = (state_reg == ST_CHECK);
        cmd.pop  = (state_reg == ST_EMIT);
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = (state_reg == ST_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DIV;
                        chunk_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (chunk_reg == CW'(NCHUNK - 1))
                        state_reg <= ST_CHECK;
                    else
                        chunk_reg <= chunk_reg + 1'b1;
                end
                ST_CHECK:
                begin
                    chunk_reg <= '0;
                    if (sts.quot_zero)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_DIV;
                end
                ST_EMIT:
                begin
                    if (sts.last_digit)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/radix_digit_converter.sv */
// Top level: converts an integer to its digits in base 2..10, MSB first.
//
//  channel  | signals                 | handshake
//  ---------+-------------------------+----------------------------------
//  input    | value, radix            | transfer when start && !busy
//  result   | digit, last             | one digit per cycle on strobe
//
// An item is divided digit by digit, C = ceil(VALUE_WIDTH/8): each digit
// costs C passes of the 8-bit-per-cycle divider and one push; the digits
// are then emitted from the stack, most significant first.
// rst_n clears the controller; the block is idle and ready after reset.
// The receiver cannot stall; busy holds off start until the last digit.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic [rdc_pkg::RADIX_W-1:0]   radix,
    output logic                          strobe,
    output logic [rdc_pkg::DIGIT_W-1:0]   digit,
    output logic                          last
);
    import rdc_pkg::*;

    localparam int NCHUNK = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

    rdc_cmd_t cmd;
    rdc_sts_t sts;

    rdc_ctrl #(
        .NCHUNK (NCHUNK)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .strobe (strobe),
        .cmd    (cmd),
        .sts    (sts)
    );

    rdc_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NCHUNK      (NCHUNK)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .value (value),
        .radix (radix),
        .digit (digit),
        .last  (last)
    );

endmodule

/* test/radix_digit_converter_test.sv */
// Testbench for radix_digit_converter: directed and random conversions checked digit by digit.
`timescale 1ns / 1ps

module radix_digit_converter_test;
    import rdc_pkg::*;

    localparam int VALUE_W        = 31;
    localparam int MAX_REPORTS    = 10;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } digit_rec_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [VALUE_W-1:0]  value;
    logic [RADIX_W-1:0]  radix;
    logic                strobe;
    logic [DIGIT_W-1:0]  digit;
    logic                last;

    digit_rec_t pending_digits[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         stall_cycles   = 0;

    radix_digit_converter #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .value (value),
        .radix (radix),
        .strobe(strobe),
        .digit (digit),
        .last  (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned effective_base(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
            return RADIX_MIN;
        if (r > RADIX_MAX)
            return RADIX_MAX;
        return r;
    endfunction

    // Queue the digits of v in base r, most significant first.
    function automatic void expand_digits(input logic [VALUE_W-1:0] v,
                                          input logic [RADIX_W-1:0] r);
        longint unsigned    rest;
        int unsigned        base;
        logic [DIGIT_W-1:0] rev[$];
        digit_rec_t         rec;
        rest = v;
        base = effective_base(r);
        do
        begin
            rev.push_front(DIGIT_W'(rest % base));
            rest = rest / base;
        end
        while (rest != 0);
        foreach (rev[i])
        begin
            rec.digit = rev[i];
            rec.last  = (i == rev.size() - 1);
            pending_digits.push_back(rec);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        value = v;
        radix = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expand_digits(v, r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_digits.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
        longint unsigned p;
        int unsigned     base;
        int unsigned     k;
        base = effective_base(r);
        case ($urandom_range(3))
            0: return VALUE_W'($urandom);
            1: return VALUE_W'($urandom) & (VALUE_MAX >> $urandom_range(VALUE_W - 1));
            2: return VALUE_W'($urandom_range(199));
            default:
            begin
                // powers of the base and one below: digit count boundaries
                p = 1;
                k = $urandom_range(1, VALUE_W - 1);
                while (k != 0 && p * base <= VALUE_MAX)
                begin
                    p = p * base;
                    k--;
                end
                return VALUE_W'(p - $urandom_range(1));
            end
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        if ($urandom_range(9) == 0)
            return RADIX_W'($urandom);
        return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endfunction

    task automatic test_single_digit();
        send_item(0, 10);
        send_item(0, 2);
        send_item(1, 2);
        send_item(9, 10);
        send_item(2, 3);
        send_item(7, 8);
    endtask

    task automatic test_extremes();
        for (int r = RADIX_MIN; r <= RADIX_MAX; r++)
            send_item(VALUE_MAX, RADIX_W'(r));
        send_item(10, 10);
        send_item(VALUE_W'(1) << (VALUE_W - 1), 2);
    endtask

    task automatic test_radix_clamp();
        send_item(0, 0);
        send_item(5, 1);
        send_item(123, 11);
        send_item(100, 12);
        send_item(VALUE_MAX, 15);
        send_item(VALUE_MAX, 0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int count);
        logic [RADIX_W-1:0] r;
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            r = pick_radix();
            send_item(pick_value(r), r);
            if (n % 40 == 39)
                wait_drained();
        end
    endtask

    task automatic test_drain_pause();
        send_item(VALUE_MAX, 2);
        send_item(3, 2);
        wait_drained();
        send_item(0, 10);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        radix = RADIX_MIN;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 26;
        test_single_digit();
        test_extremes();
        test_radix_clamp();
        test_random_traffic(26, 120);
        test_drain_pause();
        test_random_traffic(52, 120);
        test_random_traffic(0, 120);

        wait_drained();
        mismatch_count += pending_digits.size();
        if (mismatch_count == 0)
            $display("** radix_digit_converter: PASSED **");
        else
            $display("** radix_digit_converter: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        digit_rec_t want;
        if (rst_n && strobe)
        begin
            if (pending_digits.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%t: unexpected digit=%0d last=%0b", $realtime, digit, last);
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit !== want.digit || last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%t: digit exp %0d got %0d, last exp %0b got %0b",
                                 $realtime, want.digit, digit, want.last, last);
                end
            end
        end
    end

    // watchdog: cycles without any transfer or digit
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** radix_digit_converter: FAILED **");
            $finish;
        end
    end

endmodule
